### design/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Types and codes shared by the segment block allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOSPACE  = 2'd1,
    STAT_OCCUPIED = 2'd2
  } status_e;

  typedef enum logic {
    REQ_CONTIG  = 1'b0,
    REQ_SCATTER = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] owner_id;
    logic [4:0]  slot_count;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [16:0] slot_address;
    logic [3:0]  piece_number;
    logic        last;
    logic [6:0]  contiguous_free;
    logic [6:0]  total_free;
  } result_t;

  // One entry of the slot table: owning object and piece index.
  typedef struct packed {
    logic [15:0] owner;
    logic [3:0]  piece;
  } slot_entry_t;

endpackage

`default_nettype wire

### design/segment_block_allocator.sv
// Scan: a contiguous request reads up to slot_count slots from the bump
//   pointer, a scattered request up to SEGMENT_SLOTS (one slot read per cycle
//   through the single slot table read port); an error gives one error word.
// Throughput: one result word per cycle in S_EMIT while res_ready_i is high;
//   one request at a time. Reset: asynchronous, active low; then a clearing
//   pass over the whole slot table, during which no request is taken.
// ----------------------------------------------------------------------------
// segment_block_allocator
// Bump-pointer and first-fit slot allocator for one storage segment.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_block_allocator
  import sba_pkg::*;
#(
  parameter int SEGMENT_SLOTS    = 64,
  parameter int MAX_OBJECT_SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire req_t        req_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output result_t          res_o
);

  localparam int AW = $clog2(SEGMENT_SLOTS);

  logic [15:0]   segment_base_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_entry_t   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  slot_entry_t   mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segment_base_q <= '0;
    end else if (cfg_valid_i) begin
      segment_base_q <= cfg_data_i;
    end
  end

  sba_ctrl #(
    .SEGMENT_SLOTS    (SEGMENT_SLOTS),
    .MAX_OBJECT_SLOTS (MAX_OBJECT_SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .segment_base_i (segment_base_q),
    .req_valid_i    (req_valid_i),
    .req_ready_o    (req_ready_o),
    .req_i          (req_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .res_o          (res_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  sba_slot_mem #(
    .DEPTH (SEGMENT_SLOTS)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

### design/sba_slot_mem.sv
// ----------------------------------------------------------------------------
// sba_slot_mem
// Slot table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_slot_mem
  import sba_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire slot_entry_t              wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output slot_entry_t                   rdata_o
);

  slot_entry_t mem_q [DEPTH];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/sba_ctrl.sv
// ----------------------------------------------------------------------------
// sba_ctrl
// Sequencer: clears the slot table, scans it one slot per cycle, writes the
// taken slots; emits one result word per slot, or an error word, from out_q.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_ctrl
  import sba_pkg::*;
#(
  parameter int SEGMENT_SLOTS    = 64,
  parameter int MAX_OBJECT_SLOTS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [15:0]                      segment_base_i,
  input  wire logic                             req_valid_i,
  output logic                                  req_ready_o,
  input  wire req_t                             req_i,
  output logic                                  res_valid_o,
  input  wire logic                             res_ready_i,
  output result_t                               res_o,
  output logic                                  mem_we_o,
  output logic [$clog2(SEGMENT_SLOTS)-1:0]      mem_waddr_o,
  output slot_entry_t                           mem_wdata_o,
  output logic                                  mem_re_o,
  output logic [$clog2(SEGMENT_SLOTS)-1:0]      mem_raddr_o,
  input  wire slot_entry_t                      mem_rdata_i
);

  localparam int AW = $clog2(SEGMENT_SLOTS);
  localparam int CW = $clog2(SEGMENT_SLOTS + 1);
  localparam int IW = $clog2(MAX_OBJECT_SLOTS + 1);
  localparam int PW = (MAX_OBJECT_SLOTS > 1) ? $clog2(MAX_OBJECT_SLOTS) : 1;
  localparam int XW = (CW > 7) ? CW : 7;
  localparam int UW = CW + 5;
  localparam logic [CW-1:0] SLOTS_C = CW'(SEGMENT_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SEGMENT_SLOTS - 1);

  state_e        state_q, state_d;
  req_t          req_q, req_d;
  logic [CW-1:0] bump_q, bump_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] bump_run_q, bump_run_d;
  logic [CW-1:0] rd_addr_q, rd_addr_d;
  logic [CW-1:0] end_q, end_d;
  logic          chk_vld_q, chk_vld_d;
  logic [AW-1:0] chk_addr_q, chk_addr_d;
  logic [IW-1:0] found_q, found_d;
  logic [IW-1:0] emit_idx_q, emit_idx_d;
  status_e       err_q, err_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [AW-1:0] pos_q [MAX_OBJECT_SLOTS];
  logic          pos_we;
  logic          out_valid_q;
  result_t       out_q, out_d;
  logic          out_load;

  logic          out_free;
  logic [CW-1:0] contig_full;
  logic [CW-1:0] total_full;
  logic [6:0]    contig_free;
  logic [6:0]    total_free;
  logic [UW-1:0] used_sum;
  logic [CW-1:0] avail;
  logic [AW-1:0] emit_pos;
  logic          emit_last;

  assign out_free    = !out_valid_q || res_ready_i;
  assign contig_full = SLOTS_C - bump_q;
  assign total_full  = SLOTS_C - used_q;
  assign contig_free = 7'(XW'(contig_full));
  assign total_free  = 7'(XW'(total_full));
  assign used_sum    = UW'(used_q) + UW'(req_q.slot_count);
  assign avail       = SLOTS_C - bump_q;
  assign emit_pos    = pos_q[emit_idx_q[PW-1:0]];
  assign emit_last   = (emit_idx_q + IW'(1)) == found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    bump_d      = bump_q;
    used_d      = used_q;
    bump_run_d  = bump_run_q;
    rd_addr_d   = rd_addr_q;
    end_d       = end_q;
    chk_vld_d   = 1'b0;
    chk_addr_d  = chk_addr_q;
    found_d     = found_q;
    emit_idx_d  = emit_idx_q;
    err_d       = err_q;
    clr_addr_d  = clr_addr_q;
    pos_we      = 1'b0;
    out_load    = 1'b0;
    out_d       = out_q;
    req_ready_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = clr_addr_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_addr_q[AW-1:0];

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_addr_q;
        clr_addr_d  = clr_addr_q + AW'(1);
        if (clr_addr_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d      = req_i;
          found_d    = '0;
          emit_idx_d = '0;
          bump_run_d = bump_q;
          if (req_i.slot_count == 5'd0 || int'(req_i.slot_count) > MAX_OBJECT_SLOTS
              || req_i.owner_id == 16'd0) begin
            err_d   = STAT_NOSPACE;
            state_d = S_ERR;
          end else if (req_i.req_type == REQ_CONTIG) begin
            if (int'(req_i.slot_count) > int'(avail)) begin
              err_d   = STAT_NOSPACE;
              state_d = S_ERR;
            end else begin
              rd_addr_d = bump_q;
              end_d     = bump_q + CW'(req_i.slot_count);
              state_d   = S_SCAN;
            end
          end else begin
            rd_addr_d = '0;
            end_d     = SLOTS_C;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read issue runs one slot ahead of the check
        if (rd_addr_q != end_q) begin
          mem_re_o   = 1'b1;
          rd_addr_d  = rd_addr_q + CW'(1);
          chk_vld_d  = 1'b1;
          chk_addr_d = rd_addr_q[AW-1:0];
        end
        if (chk_vld_q) begin
          if (mem_rdata_i.owner == 16'd0) begin
            pos_we  = 1'b1;
            found_d = found_q + IW'(1);
            if (CW'(chk_addr_q) == bump_run_q) begin
              bump_run_d = bump_run_q + CW'(1);
            end
            if (int'(found_q) + 1 == int'(req_q.slot_count)) begin
              bump_d    = bump_run_d;
              used_d    = (used_sum > UW'(SEGMENT_SLOTS)) ? SLOTS_C : CW'(used_sum);
              chk_vld_d = 1'b0;
              state_d   = S_EMIT;
            end
          end else if (req_q.req_type == REQ_CONTIG) begin
            err_d     = STAT_OCCUPIED;
            chk_vld_d = 1'b0;
            state_d   = S_ERR;
          end
        end else if (rd_addr_q == end_q) begin
          // nothing in flight and nothing left to read
          err_d   = STAT_NOSPACE;
          state_d = S_ERR;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_d.status            = STAT_OK;
          out_d.slot_address      = 17'(segment_base_i) + 17'(emit_pos);
          out_d.piece_number      = 4'(emit_idx_q);
          out_d.last              = emit_last;
          out_d.contiguous_free   = contig_free;
          out_d.total_free        = total_free;
          mem_we_o                = 1'b1;
          mem_waddr_o             = emit_pos;
          mem_wdata_o.owner       = req_q.owner_id;
          mem_wdata_o.piece       = 4'(emit_idx_q);
          emit_idx_d              = emit_idx_q + IW'(1);
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_d.status          = err_q;
          out_d.slot_address    = '0;
          out_d.piece_number    = '0;
          out_d.last            = 1'b1;
          out_d.contiguous_free = contig_free;
          out_d.total_free      = total_free;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q      <= '0;
      used_q      <= '0;
      chk_vld_q   <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bump_q     <= bump_d;
      used_q     <= used_d;
      chk_vld_q  <= chk_vld_d;
      clr_addr_q <= clr_addr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    bump_run_q <= bump_run_d;
    rd_addr_q  <= rd_addr_d;
    end_q      <= end_d;
    chk_addr_q <= chk_addr_d;
    found_q    <= found_d;
    emit_idx_q <= emit_idx_d;
    err_q      <= err_d;
    out_q      <= out_d;
    if (pos_we) begin
      pos_q[found_q[PW-1:0]] <= chk_addr_q;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

### design/sba_checker.sv
// ----------------------------------------------------------------------------
// sba_checker
// Port-level checks on the segment block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_checker
  import sba_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    req_valid_i,
  input wire logic    req_ready_o,
  input wire logic    res_valid_o,
  input wire logic    res_ready_i,
  input wire result_t res_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("result word changed while stalled");

  // an error is a single word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STAT_OK |-> res_o.last)
    else $error("error word without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STAT_OK
      |-> res_o.slot_address == 17'd0 && res_o.piece_number == 4'd0)
    else $error("error word carries address or piece");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken while busy");

endmodule

bind segment_block_allocator sba_checker u_sba_checker (.*);

`default_nettype wire
